>>> rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared codes and fixed field widths of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

   // fixed field widths
   localparam int ADDR_W   = 32;
   localparam int ALLOC_W  = 20;
   localparam int HSIZE_W  = 21;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 32;

   // request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // register indexes
   localparam logic CSR_HEAP_BASE = 1'b0;
   localparam logic CSR_HEAP_SIZE = 1'b1;

   // register reset values
   localparam logic [ADDR_W-1:0]  RESET_HEAP_BASE = 32'd0;
   localparam logic [HSIZE_W-1:0] RESET_HEAP_SIZE = 21'd1048576;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE       = 2'd0,
      ST_NO_FIT     = 2'd1,
      ST_TABLE_FULL = 2'd2,
      ST_BAD_FREE   = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_SPARE,
      S_SPLIT_NEW,
      S_SPLIT_CUR,
      S_MERGE
   } state_type;

endpackage

`default_nettype wire

>>> rtl/ffha_seg_ram.sv
// ----------------------------------------------------------------------------
// ffha_seg_ram
// Segment table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_seg_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 46,
   parameter int AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit free-list heap allocator over an address-ordered segment table.
// ----------------------------------------------------------------------------
//  channel   ports                               transfer
//  request   req_op req_alloc_size req_free_address  start & !busy
//  response  rsp_address rsp_status              rsp_valid strobe, 1 cycle
//  config    csr_we csr_index csr_data           csr_we, immediate
//
//  An item walks the chain one table entry per cycle through the read port
//  of the segment RAM. A split adds a scan for a spare slot and then writes
//  the new slot and the current slot; a merge adds one write of the current
//  slot. A null free answers straight from idle, with no walk.
//  Reset is synchronous; slot 0 is rewritten during reset, no clearing pass.
//  The response cannot be stalled; busy stays high until it is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator #(
   parameter int MAX_SEGMENTS = 64,
   parameter int HEADER_BYTES = 12,
   parameter int OFFSET_BITS  = 20
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_op,
   input  wire logic [ffha_pkg::ALLOC_W-1:0]  req_alloc_size,
   input  wire logic [ffha_pkg::ADDR_W-1:0]   req_free_address,
   output logic                               rsp_valid,
   output logic [ffha_pkg::ADDR_W-1:0]        rsp_address,
   output logic [ffha_pkg::STATUS_W-1:0]      rsp_status,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [ffha_pkg::CSR_W-1:0]    csr_data
);

   localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int OB = OFFSET_BITS;
   localparam int EW = 2 * OB + SW;
   localparam int WW = 34;
   localparam logic [WW-1:0] HDR   = WW'(HEADER_BYTES);
   localparam logic [WW-1:0] LIMIT = WW'(1) << OB;
   localparam logic [SW-1:0] LAST  = SW'(MAX_SEGMENTS - 1);

   // sequencer and datapath registers
   ffha_pkg::state_type state_ff, state_in;
   logic [SW-1:0] cur_ff, cur_in, idx_ff, idx_in, spare_ff, spare_in;
   logic op_ff, op_in;
   logic [ffha_pkg::ALLOC_W-1:0] req_ff, req_in;
   logic [ffha_pkg::ADDR_W-1:0] target_ff, target_in, base_ff, base_in;
   logic [OB-1:0] hold_off_ff, hold_off_in, hold_size_ff, hold_size_in;
   logic [SW-1:0] hold_link_ff, hold_link_in;
   logic [MAX_SEGMENTS-1:0] free_ff, free_in, used_ff, used_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ffha_pkg::ADDR_W-1:0] rsp_address_ff, rsp_address_in;
   logic [ffha_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // RAM ports
   logic wr_en;
   logic [SW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [OB-1:0] rd_off, rd_size;
   logic [SW-1:0] rd_link;

   // rebuild value of slot 0
   logic [ffha_pkg::HSIZE_W-1:0] new_hs;
   logic [WW-1:0] total;
   logic [OB-1:0] size0;

   ffha_seg_ram #(.DEPTH(MAX_SEGMENTS), .WIDTH(EW), .AW(SW)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_off  = rd_data[EW-1 -: OB];
   assign rd_size = rd_data[SW+OB-1 -: OB];
   assign rd_link = rd_data[SW-1:0];

   // slot 0 payload after a rebuild
   always_comb begin
      new_hs = reset ? ffha_pkg::RESET_HEAP_SIZE : csr_data[ffha_pkg::HSIZE_W-1:0];
      total  = (WW'(new_hs) > LIMIT) ? LIMIT : WW'(new_hs);
      size0  = (total >= HDR) ? OB'(total - HDR) : '0;
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff      <= MAX_SEGMENTS'(1);
         used_ff      <= MAX_SEGMENTS'(1);
         base_ff      <= ffha_pkg::RESET_HEAP_BASE;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_ff      <= free_in;
         used_ff      <= used_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      idx_ff         <= idx_in;
      spare_ff       <= spare_in;
      op_ff          <= op_in;
      req_ff         <= req_in;
      target_ff      <= target_in;
      hold_off_ff    <= hold_off_in;
      hold_size_ff   <= hold_size_in;
      hold_link_ff   <= hold_link_in;
      rsp_address_ff <= rsp_address_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // next state and datapath
   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      idx_in         = idx_ff;
      spare_in       = spare_ff;
      op_in          = op_ff;
      req_in         = req_ff;
      target_in      = target_ff;
      hold_off_in    = hold_off_ff;
      hold_size_in   = hold_size_ff;
      hold_link_in   = hold_link_ff;
      free_in        = free_ff;
      used_in        = used_ff;
      base_in        = base_ff;
      rsp_valid_in   = 1'b0;
      rsp_address_in = rsp_address_ff;
      rsp_status_in  = rsp_status_ff;
      rd_addr        = cur_ff;
      wr_en          = 1'b0;
      wr_addr        = cur_ff;
      wr_data        = {hold_off_ff, hold_size_ff, hold_link_ff};

      case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (start) begin
               op_in     = req_op;
               req_in    = req_alloc_size;
               target_in = req_free_address - base_ff - ffha_pkg::ADDR_W'(HEADER_BYTES);
               cur_in    = '0;
               rd_addr   = '0;
               if (req_op == ffha_pkg::OP_FREE && req_free_address == '0) begin
                  // null free answers at once
                  rsp_valid_in   = 1'b1;
                  rsp_address_in = '0;
                  rsp_status_in  = ffha_pkg::ST_DONE;
               end else begin
                  state_in = ffha_pkg::S_WALK;
               end
            end
         end

         ffha_pkg::S_WALK: begin
            hold_off_in  = rd_off;
            hold_size_in = rd_size;
            hold_link_in = rd_link;
            if (op_ff == ffha_pkg::OP_ALLOC) begin
               if (free_ff[cur_ff] && WW'(rd_size) >= WW'(req_ff)) begin
                  if (WW'(rd_size) > WW'(req_ff) + HDR) begin
                     idx_in   = SW'(1);
                     state_in = ffha_pkg::S_SPARE;
                  end else begin
                     // small leftover: grant whole
                     free_in[cur_ff] = 1'b0;
                     rsp_valid_in    = 1'b1;
                     rsp_address_in  = ffha_pkg::ADDR_W'(WW'(base_ff) + WW'(rd_off) + HDR);
                     rsp_status_in   = ffha_pkg::ST_DONE;
                     state_in        = ffha_pkg::S_IDLE;
                  end
               end else if (rd_link == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_address_in = '0;
                  rsp_status_in  = ffha_pkg::ST_NO_FIT;
                  state_in       = ffha_pkg::S_IDLE;
               end else begin
                  cur_in  = rd_link;
                  rd_addr = rd_link;
               end
            end else begin
               if (WW'(rd_off) == WW'(target_ff)) begin
                  free_in[cur_ff] = 1'b1;
                  if (rd_link != '0 && free_ff[rd_link]) begin
                     // fetch successor for merge
                     rd_addr  = rd_link;
                     state_in = ffha_pkg::S_MERGE;
                  end else begin
                     rsp_valid_in   = 1'b1;
                     rsp_address_in = '0;
                     rsp_status_in  = ffha_pkg::ST_DONE;
                     state_in       = ffha_pkg::S_IDLE;
                  end
               end else if (rd_link == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_address_in = '0;
                  rsp_status_in  = ffha_pkg::ST_BAD_FREE;
                  state_in       = ffha_pkg::S_IDLE;
               end else begin
                  cur_in  = rd_link;
                  rd_addr = rd_link;
               end
            end
         end

         ffha_pkg::S_MERGE: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = {hold_off_ff,
                       OB'(WW'(hold_size_ff) + HDR + WW'(rd_size)),
                       rd_link};
            used_in[hold_link_ff] = 1'b0;
            free_in[hold_link_ff] = 1'b0;
            rsp_valid_in   = 1'b1;
            rsp_address_in = '0;
            rsp_status_in  = ffha_pkg::ST_DONE;
            state_in       = ffha_pkg::S_IDLE;
         end

         ffha_pkg::S_SPARE: begin
            // lowest unused slot, one per cycle
            if (!used_ff[idx_ff]) begin
               spare_in = idx_ff;
               state_in = ffha_pkg::S_SPLIT_NEW;
            end else if (idx_ff == LAST) begin
               free_in[cur_ff] = 1'b0;
               rsp_valid_in    = 1'b1;
               rsp_address_in  = ffha_pkg::ADDR_W'(WW'(base_ff) + WW'(hold_off_ff) + HDR);
               rsp_status_in   = ffha_pkg::ST_TABLE_FULL;
               state_in        = ffha_pkg::S_IDLE;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end

         ffha_pkg::S_SPLIT_NEW: begin
            wr_en   = 1'b1;
            wr_addr = spare_ff;
            wr_data = {OB'(WW'(hold_off_ff) + HDR + WW'(req_ff)),
                       OB'(WW'(hold_size_ff) - WW'(req_ff) - HDR),
                       hold_link_ff};
            used_in[spare_ff] = 1'b1;
            free_in[spare_ff] = 1'b1;
            state_in          = ffha_pkg::S_SPLIT_CUR;
         end

         ffha_pkg::S_SPLIT_CUR: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = {hold_off_ff, OB'(WW'(req_ff)), spare_ff};
            free_in[cur_ff] = 1'b0;
            rsp_valid_in    = 1'b1;
            rsp_address_in  = ffha_pkg::ADDR_W'(WW'(base_ff) + WW'(hold_off_ff) + HDR);
            rsp_status_in   = ffha_pkg::ST_DONE;
            state_in        = ffha_pkg::S_IDLE;
         end

         default: begin
            state_in = ffha_pkg::S_IDLE;
         end
      endcase

      // configuration writes; reset or a heap size write rebuilds slot 0
      if (csr_we && csr_index == ffha_pkg::CSR_HEAP_BASE) begin
         base_in = csr_data;
      end
      if (reset || (csr_we && csr_index == ffha_pkg::CSR_HEAP_SIZE)) begin
         used_in = MAX_SEGMENTS'(1);
         free_in = MAX_SEGMENTS'(1);
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = {{OB{1'b0}}, size0, {SW{1'b0}}};
      end
   end

   assign busy        = (state_ff != ffha_pkg::S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_status  = rsp_status_ff;

   // checks
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   a_bad_free_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ffha_pkg::ST_BAD_FREE) |-> rsp_address == '0)
      else $error("bad free with nonzero address");

   a_head_used: assert property (@(posedge clock) disable iff (reset)
      used_ff[0])
      else $error("head slot not in use");

   a_start_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither busy nor answered");

endmodule

`default_nettype wire
